@@ sv/md5_message_digest_assert.svh @@
// Assertion macros for the MD5 digest engine.
`ifndef MD5_MESSAGE_DIGEST_ASSERT_SVH
`define MD5_MESSAGE_DIGEST_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define MD5_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("md5: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define MD5_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("md5: next-cycle check failed");

`endif

@@ sv/md5_pkg.sv @@
// Shared types, constants and helper functions of the MD5 digest engine.
package md5_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_LEN,
		ST_LOAD,
		ST_STEP,
		ST_ADD,
		ST_EMIT
	} md5_state_t;

	// What follows the chaining add of a compression.
	typedef enum logic [1:0] {
		JOB_ABSORB,
		JOB_PAD,
		JOB_LEN,
		JOB_OUT
	} md5_job_t;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
	} md5_abcd_t;

	localparam logic [1:0] ACT_ABSORB        = 2'd0;
	localparam logic [1:0] ACT_ABSORB_FINISH = 2'd1;
	localparam logic [1:0] ACT_FINISH        = 2'd2;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	localparam md5_abcd_t INIT_CHAIN = '{
		a: 32'h67452301,
		b: 32'hefcdab89,
		c: 32'h98badcfe,
		d: 32'h10325476
	};

	localparam logic [31:0] STEP_CONST [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	localparam logic [4:0] ROT_AMOUNT [16] = '{
		5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
		5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
	};

	// Message word used by step idx, all arithmetic mod 16.
	function automatic logic [3:0] msg_index(input logic [5:0] idx);
		logic [3:0] i;
		logic [3:0] g;
		i = idx[3:0];
		unique case (idx[5:4])
			2'd0: g = i;
			2'd1: g = i + {i[1:0], 2'b00} + 4'd1;
			2'd2: g = i + {i[2:0], 1'b0} + 4'd5;
			2'd3: g = {i[0], 3'b000} - i;
			default: g = i;
		endcase
		return g;
	endfunction

	function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
		logic [63:0] dbl;
		dbl = {v, v} << s;
		return dbl[63:32];
	endfunction

	function automatic logic [31:0] bswap32(input logic [31:0] v);
		return {v[7:0], v[15:8], v[23:16], v[31:24]};
	endfunction

endpackage

@@ sv/md5_byte_if.sv @@
// Input channel: one message byte and its action code per word.
interface md5_byte_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [7:0] data_byte;

	modport source(output valid, output action, output data_byte, input ready);
	modport sink(input valid, input action, input data_byte, output ready);
endinterface

@@ sv/md5_digest_if.sv @@
// Output channel: one 128-bit digest per word, split in two halves.
interface md5_digest_if;
	logic        valid;
	logic        ready;
	logic [63:0] digest_first_half;
	logic [63:0] digest_second_half;

	modport source(output valid, output digest_first_half, output digest_second_half,
		input ready);
	modport sink(input valid, input digest_first_half, input digest_second_half,
		output ready);
endinterface

@@ sv/md5_step.sv @@
// One MD5 compression step: round function, add, rotate and word shift.
module md5_step (
	input  md5_pkg::md5_abcd_t cur,
	input  logic [31:0]        km,
	input  logic [5:0]         idx,
	output md5_pkg::md5_abcd_t nxt
);

	logic [31:0] f;
	logic [31:0] sum;
	logic [31:0] rot;

	always_comb begin
		unique case (idx[5:4])
			2'd0: f = ((cur.c ^ cur.d) & cur.b) ^ cur.d;
			2'd1: f = ((cur.b ^ cur.c) & cur.d) ^ cur.c;
			2'd2: f = cur.b ^ cur.c ^ cur.d;
			2'd3: f = (~cur.d | cur.b) ^ cur.c;
			default: f = cur.b ^ cur.c ^ cur.d;
		endcase
	end

	// km already holds step constant plus message word
	assign sum = cur.a + f + km;
	assign rot = md5_pkg::rotl32(sum, md5_pkg::ROT_AMOUNT[{idx[5:4], idx[1:0]}]);

	assign nxt.a = cur.d;
	assign nxt.b = rot + cur.b;
	assign nxt.c = cur.b;
	assign nxt.d = cur.c;

endmodule

@@ sv/md5_message_digest.sv @@
// Top level of the streaming MD5 digest engine.
//
//   channel   dir   payload                                   role
//   bytes     in    action[1:0], data_byte[7:0]               message bytes and finish
//   digest    out   digest_first_half, digest_second_half     128-bit digest
//
// A byte word is taken when offered while bytes.ready is high, which is only while the sequencer idles.
// A full 64-byte block then passes through the single step unit (load, 64 steps,
// chaining add), and no new bytes are taken until that compression is done.
// Finish adds pad, length, one or two compressions and an emit state.
// The digest sits in an output register; new bytes are taken while it waits.
// Reset (arst_n low) restores the initial chaining words, fill and length at once.
`include "md5_message_digest_assert.svh"

module md5_message_digest (
	input  logic        clk,
	input  logic        arst_n,
	md5_byte_if.sink    bytes,
	md5_digest_if.source digest
);

	md5_pkg::md5_state_t state_q, state_d;
	md5_pkg::md5_job_t   job_q, job_d;

	logic        long_q;         // finish needs a second block for the length
	logic [5:0]  fill_q;         // bytes pending in the block
	logic [60:0] nbytes_q;       // message length in bytes, bit length mod 2^64
	logic [5:0]  step_q;
	logic [31:0] km_q;
	logic [31:0] blk_q [16];

	md5_pkg::md5_abcd_t chain_q;
	md5_pkg::md5_abcd_t work_q;
	md5_pkg::md5_abcd_t work_nxt;

	logic        out_valid_q;
	logic [63:0] out_first_q;
	logic [63:0] out_second_q;

	// control decode
	logic        accept;
	logic        has_byte;
	logic        wants_fin;
	logic        blk_full;
	logic        emit_fire;
	logic        wr_byte_en;
	logic [7:0]  wr_byte;
	logic [63:0] bit_len;
	logic [5:0]  km_idx;
	logic [31:0] km_d;

	// Merge one byte into its word; a byte that starts a word clears the rest.
	function automatic logic [31:0] put_byte(input logic [31:0] w, input logic [7:0] b,
		input logic [1:0] pos);
		logic [31:0] shifted;
		shifted = {24'd0, b} << {pos, 3'b000};
		return (pos == 2'd0) ? shifted : (w | shifted);
	endfunction

	assign bytes.ready               = (state_q == md5_pkg::ST_IDLE);
	assign digest.valid              = out_valid_q;
	assign digest.digest_first_half  = out_first_q;
	assign digest.digest_second_half = out_second_q;

	always_comb begin
		accept    = bytes.valid && bytes.ready;
		has_byte  = accept && (bytes.action == md5_pkg::ACT_ABSORB ||
			bytes.action == md5_pkg::ACT_ABSORB_FINISH);
		wants_fin = accept && (bytes.action == md5_pkg::ACT_ABSORB_FINISH ||
			bytes.action == md5_pkg::ACT_FINISH);
		blk_full  = has_byte && (fill_q == 6'd63);
		emit_fire = (state_q == md5_pkg::ST_EMIT) && (!out_valid_q || digest.ready);
		// pad writes 0x80 at the fill position the same way a message byte goes in
		wr_byte_en = has_byte || (state_q == md5_pkg::ST_PAD);
		wr_byte    = (state_q == md5_pkg::ST_PAD) ? md5_pkg::PAD_BYTE : bytes.data_byte;
		bit_len    = {nbytes_q, 3'b000};
		// prefetch constant plus message word for the next step
		km_idx = (state_q == md5_pkg::ST_LOAD) ? 6'd0 : step_q + 6'd1;
		km_d   = md5_pkg::STEP_CONST[km_idx] + blk_q[md5_pkg::msg_index(km_idx)];
	end

	// next state
	always_comb begin
		state_d = state_q;
		job_d   = job_q;
		unique case (state_q)
			md5_pkg::ST_IDLE: begin
				if (blk_full) begin
					state_d = md5_pkg::ST_LOAD;
					job_d   = wants_fin ? md5_pkg::JOB_PAD : md5_pkg::JOB_ABSORB;
				end else if (wants_fin) begin
					state_d = md5_pkg::ST_PAD;
				end
			end
			md5_pkg::ST_PAD: begin
				if (fill_q[5:3] == 3'b111) begin
					state_d = md5_pkg::ST_LOAD;
					job_d   = md5_pkg::JOB_LEN;
				end else begin
					state_d = md5_pkg::ST_LEN;
				end
			end
			md5_pkg::ST_LEN: begin
				state_d = md5_pkg::ST_LOAD;
				job_d   = md5_pkg::JOB_OUT;
			end
			md5_pkg::ST_LOAD: state_d = md5_pkg::ST_STEP;
			md5_pkg::ST_STEP: begin
				if (step_q == 6'd63) begin
					state_d = md5_pkg::ST_ADD;
				end
			end
			md5_pkg::ST_ADD: begin
				unique case (job_q)
					md5_pkg::JOB_ABSORB: state_d = md5_pkg::ST_IDLE;
					md5_pkg::JOB_PAD:    state_d = md5_pkg::ST_PAD;
					md5_pkg::JOB_LEN:    state_d = md5_pkg::ST_LEN;
					md5_pkg::JOB_OUT:    state_d = md5_pkg::ST_EMIT;
					default:             state_d = md5_pkg::ST_IDLE;
				endcase
			end
			md5_pkg::ST_EMIT: begin
				if (emit_fire) begin
					state_d = md5_pkg::ST_IDLE;
				end
			end
			default: state_d = md5_pkg::ST_IDLE;
		endcase
	end

	md5_step u_step (
		.cur (work_q),
		.km  (km_q),
		.idx (step_q),
		.nxt (work_nxt)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= md5_pkg::ST_IDLE;
			job_q       <= md5_pkg::JOB_ABSORB;
			long_q      <= 1'b0;
			fill_q      <= 6'd0;
			nbytes_q    <= 61'd0;
			step_q      <= 6'd0;
			chain_q     <= md5_pkg::INIT_CHAIN;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			job_q   <= job_d;
			if (has_byte) begin
				fill_q   <= fill_q + 6'd1;
				nbytes_q <= nbytes_q + 61'd1;
			end
			if (state_q == md5_pkg::ST_PAD) begin
				// remember whether the length goes in a block of its own
				long_q <= (fill_q[5:3] == 3'b111);
				fill_q <= 6'd0;
			end
			if (state_q == md5_pkg::ST_LOAD) begin
				step_q <= 6'd0;
			end else if (state_q == md5_pkg::ST_STEP) begin
				step_q <= step_q + 6'd1;
			end
			if (state_q == md5_pkg::ST_ADD) begin
				chain_q.a <= chain_q.a + work_q.a;
				chain_q.b <= chain_q.b + work_q.b;
				chain_q.c <= chain_q.c + work_q.c;
				chain_q.d <= chain_q.d + work_q.d;
			end
			if (emit_fire) begin
				// start the next message from the initial chaining words
				chain_q     <= md5_pkg::INIT_CHAIN;
				nbytes_q    <= 61'd0;
				out_valid_q <= 1'b1;
			end else if (digest.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload: working words, prefetched step operand, digest register
	always_ff @(posedge clk) begin
		if (state_q == md5_pkg::ST_LOAD) begin
			work_q <= chain_q;
		end else if (state_q == md5_pkg::ST_STEP) begin
			work_q <= work_nxt;
		end
		if (state_q == md5_pkg::ST_LOAD || state_q == md5_pkg::ST_STEP) begin
			km_q <= km_d;
		end
		if (emit_fire) begin
			out_first_q  <= {md5_pkg::bswap32(chain_q.a), md5_pkg::bswap32(chain_q.b)};
			out_second_q <= {md5_pkg::bswap32(chain_q.c), md5_pkg::bswap32(chain_q.d)};
		end
	end

	// block buffer: each word updates in place
	always_ff @(posedge clk) begin
		for (int k = 0; k < 16; k++) begin
			if (wr_byte_en && (4'(k) == fill_q[5:2])) begin
				blk_q[k] <= put_byte(blk_q[k], wr_byte, fill_q[1:0]);
			end else if ((state_q == md5_pkg::ST_PAD) && (4'(k) > fill_q[5:2])) begin
				// zero the words past the pad byte
				blk_q[k] <= 32'd0;
			end else if (state_q == md5_pkg::ST_LEN) begin
				if (k == 14) begin
					blk_q[k] <= bit_len[31:0];
				end else if (k == 15) begin
					blk_q[k] <= bit_len[63:32];
				end else if (long_q) begin
					blk_q[k] <= 32'd0;
				end
			end
		end
	end

	`MD5_ASSERT_SAME(a_out_from_emit, clk, arst_n, $rose(out_valid_q), $past(state_q) == md5_pkg::ST_EMIT)
	`MD5_ASSERT_SAME(a_load_block_aligned, clk, arst_n, state_q == md5_pkg::ST_LOAD, fill_q == 6'd0)
	`MD5_ASSERT_NEXT(a_restart_after_emit, clk, arst_n, emit_fire, (chain_q == md5_pkg::INIT_CHAIN) && (nbytes_q == 61'd0))

endmodule

@@ tb/sv/md5_message_digest_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the streaming MD5 digest engine, with its own MD5 predictor.
module md5_message_digest_tb;

	// The fourth action code carries no meaning: the block must drop it.
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	localparam int BYTE_TARGET  = 760;
	localparam int MSG_TARGET   = 16;
	localparam int TAIL_CYCLES  = 300;
	localparam int CYCLE_LIMIT  = 3_000_000;

	// Per-step additive constants and rotate amounts of the compression.
	localparam logic [31:0] ROUND_ADD [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};
	localparam int ROUND_SHIFT [16] = '{
		7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
	};

	// One pending byte word: payload, idle cycles before it, and whether it
	// must wait until every digest in flight has come out.
	typedef struct {
		logic [1:0] action;
		logic [7:0] data;
		int         gap;
		bit         drain;
	} byte_word_t;

	typedef struct {
		logic [63:0] first_half;
		logic [63:0] second_half;
	} digest_pair_t;

	logic clk;
	logic arst_n    = 1'b0;
	logic in_valid  = 1'b0;
	logic [1:0] in_action = md5_pkg::ACT_ABSORB;
	logic [7:0] in_byte   = 8'h00;
	logic out_ready = 1'b0;

	md5_byte_if   byte_ch();
	md5_digest_if digest_ch();

	assign byte_ch.valid     = in_valid;
	assign byte_ch.action    = in_action;
	assign byte_ch.data_byte = in_byte;
	assign digest_ch.ready   = out_ready;

	md5_message_digest dut (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (byte_ch),
		.digest (digest_ch)
	);

	// Stimulus and scoreboard storage.
	byte_word_t   byte_words[$];
	digest_pair_t pending_digests[$];

	// Predictor state: chaining words, block buffer, fill and bit count.
	logic [31:0] hash_state [4];
	logic [31:0] msg_block [16];
	logic [5:0]  fill_count;
	logic [63:0] msg_bits;

	int mismatches      = 0;
	int digests_checked = 0;
	int bytes_fed       = 0;
	int noise_words     = 0;
	int messages_built  = 0;
	int drain_pauses    = 0;
	int cycle_count     = 0;
	bit started         = 1'b0;
	bit word_taken      = 1'b0;
	bit holding         = 1'b0;
	bit sender_calm     = 1'b0;
	byte_word_t cur_word;
	int gap_left        = 0;
	int stall_left      = 0;
	int phase_left      = 0;
	bit sink_calm       = 1'b0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------

	function automatic logic [31:0] rot_left(logic [31:0] v, int n);
		if (n % 32 == 0)
			return v;
		return (v << (n % 32)) | (v >> (32 - n % 32));
	endfunction

	// Restore the chaining words, fill and length of a fresh message.
	function automatic void start_message();
		hash_state[0] = 32'h67452301;
		hash_state[1] = 32'hefcdab89;
		hash_state[2] = 32'h98badcfe;
		hash_state[3] = 32'h10325476;
		fill_count    = '0;
		msg_bits      = '0;
	endfunction

	// Run the 64 steps over the buffered block and fold into the chain.
	function automatic void compress_block();
		logic [31:0] a, b, c, d, f, t;
		int g;
		int rnd;
		a = hash_state[0];
		b = hash_state[1];
		c = hash_state[2];
		d = hash_state[3];
		for (int i = 0; i < 64; i++) begin
			rnd = i / 16;
			case (rnd)
				0: begin
					f = (b & c) | (~b & d);
					g = i;
				end
				1: begin
					f = (b & d) | (c & ~d);
					g = (5 * i + 1) % 16;
				end
				2: begin
					f = b ^ c ^ d;
					g = (3 * i + 5) % 16;
				end
				default: begin
					f = c ^ (b | ~d);
					g = (7 * i) % 16;
				end
			endcase
			t = a + f + ROUND_ADD[i] + msg_block[g];
			t = rot_left(t, ROUND_SHIFT[rnd * 4 + i % 4]) + b;
			a = d;
			d = c;
			c = b;
			b = t;
		end
		hash_state[0] = hash_state[0] + a;
		hash_state[1] = hash_state[1] + b;
		hash_state[2] = hash_state[2] + c;
		hash_state[3] = hash_state[3] + d;
	endfunction

	// Pack one byte little-endian; a byte at a word boundary replaces the word.
	function automatic void pack_byte(logic [7:0] value);
		if (fill_count[1:0] == 2'd0)
			msg_block[fill_count[5:2]] = {24'h0, value};
		else
			msg_block[fill_count[5:2]] = msg_block[fill_count[5:2]] |
				({24'h0, value} << {fill_count[1:0], 3'b000});
		fill_count = fill_count + 6'd1;
		if (fill_count == 6'd0)
			compress_block();
	endfunction

	// Pad, append the bit length, compress and return the digest bytes.
	function automatic digest_pair_t close_message();
		digest_pair_t res;
		int pending;
		int i;
		logic [63:0] len;
		logic [31:0] w [4];
		pending = int'(fill_count);
		len     = msg_bits;
		pack_byte(md5_pkg::PAD_BYTE);
		if (pending >= 56) begin
			// Length does not fit: flush this block, then a block of zeros.
			if (fill_count != 6'd0) begin
				for (i = (int'(fill_count) + 3) / 4; i < 16; i++)
					msg_block[i] = '0;
				compress_block();
			end
			fill_count = '0;
			for (i = 0; i < 14; i++)
				msg_block[i] = '0;
		end else begin
			for (i = (int'(fill_count) + 3) / 4; i < 14; i++)
				msg_block[i] = '0;
		end
		msg_block[14] = len[31:0];
		msg_block[15] = len[63:32];
		compress_block();
		for (i = 0; i < 4; i++)
			w[i] = {hash_state[i][7:0], hash_state[i][15:8],
				hash_state[i][23:16], hash_state[i][31:24]};
		res.first_half  = {w[0], w[1]};
		res.second_half = {w[2], w[3]};
		start_message();
		return res;
	endfunction

	// Apply one accepted byte word; queue a digest when it finishes a message.
	function automatic void predict_word(logic [1:0] act, logic [7:0] value);
		if (act == ACT_UNUSED)
			return;
		if (act != md5_pkg::ACT_FINISH) begin
			pack_byte(value);
			msg_bits = msg_bits + 64'd8;
		end
		if (act == md5_pkg::ACT_ABSORB)
			return;
		pending_digests.push_back(close_message());
	endfunction

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------

	// Most gaps are zero or short; a few stretch past a whole compression.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 20);
		return $urandom_range(50, 200);
	endfunction

	function automatic void add_word(logic [1:0] act, logic [7:0] value, bit drain);
		byte_word_t w;
		w.action = act;
		w.data   = value;
		w.gap    = sender_calm ? 0 : pick_gap();
		w.drain  = drain;
		byte_words.push_back(w);
		if (act == ACT_UNUSED)
			noise_words++;
		else if (act != md5_pkg::ACT_FINISH)
			bytes_fed++;
	endfunction

	// Queue one message of random length and content, ended either by the
	// last byte or by a separate finish word; sprinkle in dropped words.
	function automatic void add_random_message(bit drain);
		int len;
		int r;
		bit split_finish;
		r = $urandom_range(0, 99);
		if (r < 35)
			len = $urandom_range(0, 8);
		else if (r < 60)
			len = $urandom_range(9, 54);
		else if (r < 88)
			len = $urandom_range(55, 65);
		else
			len = $urandom_range(66, 140);
		split_finish = (len == 0) || ($urandom_range(0, 1) == 1);
		sender_calm  = ($urandom_range(0, 3) == 0);
		for (int k = 0; k < len; k++) begin
			if ($urandom_range(0, 99) < 3)
				add_word(ACT_UNUSED, 8'($urandom), 1'b0);
			if (k == len - 1 && !split_finish)
				add_word(md5_pkg::ACT_ABSORB_FINISH, 8'($urandom), drain && k == 0);
			else
				add_word(md5_pkg::ACT_ABSORB, 8'($urandom), drain && k == 0);
		end
		if (split_finish)
			add_word(md5_pkg::ACT_FINISH, 8'($urandom), drain && len == 0);
		messages_built++;
	endfunction

	task automatic build_stimulus();
		// Empty message, then a dropped word carrying all ones.
		add_word(md5_pkg::ACT_FINISH, 8'hA5, 1'b0);
		add_word(ACT_UNUSED, 8'hFF, 1'b0);
		// Single-byte messages at both byte extremes.
		add_word(md5_pkg::ACT_ABSORB_FINISH, 8'h00, 1'b0);
		add_word(md5_pkg::ACT_ABSORB_FINISH, 8'hFF, 1'b0);
		// "abc", then an empty message right behind it.
		add_word(md5_pkg::ACT_ABSORB, 8'h61, 1'b0);
		add_word(md5_pkg::ACT_ABSORB, 8'h62, 1'b0);
		add_word(md5_pkg::ACT_ABSORB_FINISH, 8'h63, 1'b0);
		add_word(md5_pkg::ACT_FINISH, 8'h00, 1'b0);
		// Dropped word in the middle of a message.
		add_word(md5_pkg::ACT_ABSORB, 8'h61, 1'b0);
		add_word(ACT_UNUSED, 8'h00, 1'b0);
		add_word(md5_pkg::ACT_FINISH, 8'h5A, 1'b0);
		messages_built = 6;
		// Random messages; the first one waits for the directed digests.
		add_random_message(1'b1);
		while (bytes_fed < BYTE_TARGET || messages_built < MSG_TARGET)
			add_random_message($urandom_range(0, 9) == 0);
	endtask

	// ---------------------------------------------------------------
	// Checking
	// ---------------------------------------------------------------

	task automatic report_mismatch(string msg);
		mismatches++;
		$display("mismatch at cycle %0d: %s", cycle_count, msg);
	endtask

	// ---------------------------------------------------------------
	// Byte driver: change inputs at the falling edge only
	// ---------------------------------------------------------------

	always @(negedge clk) begin : drive_bytes
		logic next_valid;
		next_valid = in_valid;
		if (started) begin
			// Drop the word the last rising edge took.
			if (in_valid && word_taken) begin
				next_valid = 1'b0;
				holding    = 1'b0;
			end
			if (!next_valid) begin
				if (!holding && byte_words.size() != 0) begin
					cur_word = byte_words.pop_front();
					holding  = 1'b1;
					gap_left = cur_word.gap;
					if (cur_word.drain)
						drain_pauses++;
				end
				if (holding) begin
					if (gap_left > 0) begin
						gap_left--;
					end else if (!cur_word.drain || pending_digests.size() == 0) begin
						// Present the word; hold it until the block takes it.
						next_valid = 1'b1;
						in_action <= cur_word.action;
						in_byte   <= cur_word.data;
					end
				end
			end
		end
		// One write of valid per edge, so a back-to-back word never drops it.
		in_valid <= next_valid;
	end

	// ---------------------------------------------------------------
	// Digest sink: random back-pressure, with calm stretches
	// ---------------------------------------------------------------

	always @(negedge clk) begin
		if (phase_left == 0) begin
			sink_calm  = ($urandom_range(0, 3) == 0);
			phase_left = $urandom_range(100, 2000);
		end
		phase_left--;
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if (!sink_calm && $urandom_range(0, 2) == 0)
				stall_left = pick_gap();
		end
	end

	// ---------------------------------------------------------------
	// Monitor: sample both channels at the rising edge
	// ---------------------------------------------------------------

	always @(posedge clk) begin : watch_channels
		digest_pair_t want;
		word_taken <= in_valid && byte_ch.ready;
		// Advance the predictor on every byte word the block takes.
		if (in_valid && byte_ch.ready)
			predict_word(in_action, in_byte);
		if (digest_ch.valid && out_ready) begin
			if (pending_digests.size() == 0) begin
				report_mismatch($sformatf("digest %h_%h with none expected",
					digest_ch.digest_first_half, digest_ch.digest_second_half));
			end else begin
				want = pending_digests.pop_front();
				if (digest_ch.digest_first_half !== want.first_half)
					report_mismatch($sformatf("digest %0d first half %h, expected %h",
						digests_checked, digest_ch.digest_first_half, want.first_half));
				if (digest_ch.digest_second_half !== want.second_half)
					report_mismatch($sformatf("digest %0d second half %h, expected %h",
						digests_checked, digest_ch.digest_second_half, want.second_half));
			end
			digests_checked++;
		end
	end

	// Stop a hung run.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d digests outstanding",
			cycle_count, pending_digests.size());
		$display("FAILED: results differ");
		$finish;
	end

	// ---------------------------------------------------------------
	// Sequence: reset, run, drain, verdict
	// ---------------------------------------------------------------

	initial begin
		for (int i = 0; i < 16; i++)
			msg_block[i] = '0;
		start_message();
		build_stimulus();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);
		started = 1'b1;
		// Wait for every word to go in and every digest to come out.
		while (byte_words.size() != 0 || holding || in_valid || pending_digests.size() != 0)
			@(posedge clk);
		// Let any trailing compression settle; nothing more may come out.
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_digests.size() != 0)
			report_mismatch($sformatf("%0d digests never arrived", pending_digests.size()));
		$display("covered %0d messages: %0d bytes, %0d dropped words, %0d drain pauses",
			messages_built, bytes_fed, noise_words, drain_pauses);
		$display("checked %0d digests in %0d cycles, %0d mismatches",
			digests_checked, cycle_count, mismatches);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

@@ md5_message_digest.f @@
+incdir+sv
sv/md5_pkg.sv
sv/md5_byte_if.sv
sv/md5_digest_if.sv
sv/md5_step.sv
sv/md5_message_digest.sv
tb/sv/md5_message_digest_tb.sv
